// ===== hdl/wswa_pkg.sv =====
// ----------------------------------------------------------------------------
// Wind speed window averager: shared definitions
// Field widths, register indexes, reset values and the Beaufort threshold table.
// ----------------------------------------------------------------------------
package wswa_pkg;

    localparam int COUNT_W    = 16;
    localparam int SPEED_W    = 16;
    localparam int HOLD_W     = 8;
    localparam int SKIP_W     = 8;
    localparam int BFT_W      = 5;
    localparam int RECIP_W    = COUNT_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 56;

    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int RECENT_DEPTH_DEF = 4;
    localparam int BEAUFORT_MAX     = 17;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_PER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_INTERVALS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_SKIP     = 2'd2;

    localparam logic [SPEED_W-1:0] SPEED_PER_COUNT_RST = 16'd256;
    localparam logic [HOLD_W-1:0]  HOLD_INTERVALS_RST  = 8'd5;
    localparam logic [SKIP_W-1:0]  REPORT_SKIP_RST     = 8'd5;

    // Q8.8 m/s threshold of each Beaufort number, 0.836 * B^1.5 rounded up
    function automatic logic [31:0] bft_threshold(input logic [BFT_W-1:0] b);
        logic [31:0] thr;
        unique case (b)
            5'd0:  thr = 32'd0;
            5'd1:  thr = 32'd215;
            5'd2:  thr = 32'd606;
            5'd3:  thr = 32'd1113;
            5'd4:  thr = 32'd1713;
            5'd5:  thr = 32'd2393;
            5'd6:  thr = 32'd3146;
            5'd7:  thr = 32'd3964;
            5'd8:  thr = 32'd4843;
            5'd9:  thr = 32'd5779;
            5'd10: thr = 32'd6768;
            5'd11: thr = 32'd7808;
            5'd12: thr = 32'd8897;
            5'd13: thr = 32'd10032;
            5'd14: thr = 32'd11211;
            5'd15: thr = 32'd12434;
            5'd16: thr = 32'd13698;
            5'd17: thr = 32'd15001;
            5'd18: thr = 32'd16344;
            5'd19: thr = 32'd17725;
            5'd20: thr = 32'd19143;
            5'd21: thr = 32'd20596;
            5'd22: thr = 32'd22085;
            5'd23: thr = 32'd23607;
            5'd24: thr = 32'd25164;
            5'd25: thr = 32'd26752;
            5'd26: thr = 32'd28374;
            5'd27: thr = 32'd30026;
            5'd28: thr = 32'd31710;
            5'd29: thr = 32'd33423;
            5'd30: thr = 32'd35167;
            5'd31: thr = 32'd36940;
            default: thr = 32'd0;
        endcase
        return thr;
    endfunction

endpackage

// ===== hdl/wind_speed_window_averager_top.sv =====
// ----------------------------------------------------------------------------
// Wind speed window averager
// Hold rule, sliding window averages, gust and Beaufort reporting per interval.
// ----------------------------------------------------------------------------
// Usage:
//   Send one anemometer pulse count per refresh interval on the s_ stream.
//   Each item yields exactly one result item on the m_ stream, in order:
//   window average, gust average, last reported gust speed (Q8.8 m/s),
//   last reported Beaufort number and the report and change flags.
//   Configuration is written on the cfg_ channel (always ready) while the
//   block is idle: index 0 speed per count, 1 hold intervals, 2 report skip;
//   other indexes are ignored.
//   One item per cycle is sustained while m_tready is high. The window state
//   updates at the accept edge, then the divide estimate, divide correction,
//   speed multiply and Beaufort/report stages follow, each one register
//   deep.
//   Reset clears the window, all sums, the hold and report counters and the
//   reported values, and restores the register defaults; the first item
//   after reset evaluates a report.
//   When m_tready is low the result holds in the output register; the
//   pipeline keeps filling its empty stages and s_tready drops only once all
//   of them hold an item.
// ----------------------------------------------------------------------------
module wind_speed_window_averager_top
    import wswa_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int RECENT_DEPTH = RECENT_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [COUNT_W-1:0]    s_tdata,   // [15:0] pulse_count
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [15:0] average_count, [31:16] gust_count,
                                             // [47:32] reported_gust_speed,
                                             // [52:48] reported_beaufort, [53] report_tick,
                                             // [54] gust_changed, [55] beaufort_changed
);

    localparam int RECENT_EFF = (RECENT_DEPTH > WINDOW_DEPTH) ? WINDOW_DEPTH : RECENT_DEPTH;
    localparam int WIN_LOG    = $clog2(WINDOW_DEPTH);
    localparam int REC_LOG    = $clog2(RECENT_EFF);
    localparam int WIN_SUM_W  = COUNT_W + WIN_LOG;
    localparam int REC_SUM_W  = COUNT_W + REC_LOG;
    localparam int AVG_SHIFT  = COUNT_W + WIN_LOG;
    localparam int REC_SHIFT  = COUNT_W + REC_LOG;
    localparam int AVG_PROD_W = WIN_SUM_W + RECIP_W;
    localparam int REC_PROD_W = REC_SUM_W + RECIP_W;
    localparam int SPD_PROD_W = COUNT_W + SPEED_W;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'((64'd1 << AVG_SHIFT) / 64'(WINDOW_DEPTH));
    localparam logic [RECIP_W-1:0] REC_RECIP =
        RECIP_W'((64'd1 << REC_SHIFT) / 64'(RECENT_EFF));
    localparam logic [WIN_SUM_W-1:0] WIN_DIV = WIN_SUM_W'(WINDOW_DEPTH);
    localparam logic [REC_SUM_W-1:0] REC_DIV = REC_SUM_W'(RECENT_EFF);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SPEED_W-1:0] speed_per_count_reg;
    logic [HOLD_W-1:0]  hold_intervals_reg;
    logic [SKIP_W-1:0]  report_skip_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_per_count_reg <= SPEED_PER_COUNT_RST;
            hold_intervals_reg  <= HOLD_INTERVALS_RST;
            report_skip_reg     <= REPORT_SKIP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SPEED_PER_COUNT: speed_per_count_reg <= cfg_data;
                REG_HOLD_INTERVALS:  hold_intervals_reg  <= cfg_data[HOLD_W-1:0];
                REG_REPORT_SKIP:     report_skip_reg     <= cfg_data[SKIP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: each stage loads when empty or when the next one moves
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic en_out, en4, en3, en2, en1;
    logic s_accept;

    assign en_out   = !out_valid_reg || m_tready;
    assign en4      = !s4_valid_reg || en_out;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign s_tready = en1;
    assign s_accept = s_tvalid && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)    s1_valid_reg  <= s_tvalid;
            if (en2)    s2_valid_reg  <= s1_valid_reg;
            if (en3)    s3_valid_reg  <= s2_valid_reg;
            if (en4)    s4_valid_reg  <= s3_valid_reg;
            if (en_out) out_valid_reg <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: hold rule, window shift and running sums
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]   win_reg [WINDOW_DEPTH];
    logic [WIN_SUM_W-1:0] win_total_reg, win_total_next;
    logic [REC_SUM_W-1:0] rec_total_reg, rec_total_next;
    logic [COUNT_W-1:0]   held_reg, held_next;
    logic [HOLD_W-1:0]    hold_left_reg, hold_left_next;
    logic [SKIP_W-1:0]    skip_left_reg, skip_left_next;
    logic [COUNT_W-1:0]   sample;
    logic [COUNT_W:0]     mean_sum;
    logic [HOLD_W-1:0]    hold_eff;
    logic                 report_now;

    always_comb
    begin
        mean_sum = {1'b0, held_reg} + {1'b0, s_tdata};
        if (s_tdata == '0)
            sample = held_reg;
        else if (s_tdata < held_reg)
            sample = mean_sum[COUNT_W:1];
        else
            sample = s_tdata;

        hold_eff = (s_tdata != '0) ? hold_intervals_reg : hold_left_reg;
        if (hold_eff == '0)
        begin
            held_next      = '0;
            hold_left_next = '0;
        end
        else
        begin
            held_next      = (s_tdata != '0) ? sample : held_reg;
            hold_left_next = hold_eff - 1'b1;
        end

        win_total_next = win_total_reg + WIN_SUM_W'(sample) - WIN_SUM_W'(win_reg[0]);
        rec_total_next = rec_total_reg + REC_SUM_W'(sample)
                       - REC_SUM_W'(win_reg[WINDOW_DEPTH - RECENT_EFF]);

        report_now     = (skip_left_reg == '0);
        skip_left_next = report_now ? report_skip_reg : skip_left_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
                win_reg[i] <= '0;
            win_total_reg <= '0;
            rec_total_reg <= '0;
            held_reg      <= '0;
            hold_left_reg <= '0;
            skip_left_reg <= '0;
        end
        else if (s_accept)
        begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[WINDOW_DEPTH - 1] <= sample;
            win_total_reg <= win_total_next;
            rec_total_reg <= rec_total_next;
            held_reg      <= held_next;
            hold_left_reg <= hold_left_next;
            skip_left_reg <= skip_left_next;
        end
    end

    logic [WIN_SUM_W-1:0] s1_win_total_reg;
    logic [REC_SUM_W-1:0] s1_rec_total_reg;
    logic                 s1_tick_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_win_total_reg <= win_total_next;
            s1_rec_total_reg <= rec_total_next;
            s1_tick_reg      <= report_now;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: quotient estimate by reciprocal multiply (low by at most one)
    // ------------------------------------------------------------------
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [REC_PROD_W-1:0] rec_prod;
    logic [WIN_SUM_W-1:0]  s2_win_total_reg;
    logic [REC_SUM_W-1:0]  s2_rec_total_reg;
    logic [COUNT_W-1:0]    s2_avg_est_reg, s2_gust_est_reg;
    logic                  s2_tick_reg;

    assign avg_prod = AVG_PROD_W'(s1_win_total_reg) * AVG_PROD_W'(AVG_RECIP);
    assign rec_prod = REC_PROD_W'(s1_rec_total_reg) * REC_PROD_W'(REC_RECIP);

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_win_total_reg <= s1_win_total_reg;
            s2_rec_total_reg <= s1_rec_total_reg;
            s2_avg_est_reg   <= avg_prod[AVG_SHIFT +: COUNT_W];
            s2_gust_est_reg  <= rec_prod[REC_SHIFT +: COUNT_W];
            s2_tick_reg      <= s1_tick_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: remainder check and quotient correction
    // ------------------------------------------------------------------
    logic [WIN_SUM_W-1:0] avg_rem;
    logic [REC_SUM_W-1:0] rec_rem;
    logic [COUNT_W-1:0]   s3_avg_reg, s3_gust_reg;
    logic                 s3_tick_reg;

    assign avg_rem = s2_win_total_reg - WIN_SUM_W'(WIN_SUM_W'(s2_avg_est_reg) * WIN_DIV);
    assign rec_rem = s2_rec_total_reg - REC_SUM_W'(REC_SUM_W'(s2_gust_est_reg) * REC_DIV);

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_avg_reg  <= s2_avg_est_reg + COUNT_W'(avg_rem >= WIN_DIV);
            s3_gust_reg <= s2_gust_est_reg + COUNT_W'(rec_rem >= REC_DIV);
            s3_tick_reg <= s2_tick_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: speeds in Q8.8
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]    s4_avg_reg, s4_gust_reg;
    logic [SPD_PROD_W-1:0] s4_gust_speed_reg, s4_avg_speed_reg;
    logic                  s4_tick_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_avg_reg        <= s3_avg_reg;
            s4_gust_reg       <= s3_gust_reg;
            s4_gust_speed_reg <= SPD_PROD_W'(s3_gust_reg) * SPD_PROD_W'(speed_per_count_reg);
            s4_avg_speed_reg  <= SPD_PROD_W'(s3_avg_reg) * SPD_PROD_W'(speed_per_count_reg);
            s4_tick_reg       <= s3_tick_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: saturate, Beaufort lookup, compare with last report
    // ------------------------------------------------------------------
    logic [SPEED_W-1:0] last_gust_reg, last_gust_next;
    logic [BFT_W-1:0]   last_bft_reg, last_bft_next;
    logic [SPEED_W-1:0] gust_sat;
    logic [BFT_W-1:0]   bft;
    logic               gust_chg, bft_chg;

    always_comb
    begin
        gust_sat = (|s4_gust_speed_reg[COUNT_W+SPEED_W-1:SPEED_W]) ? '1
                 : s4_gust_speed_reg[SPEED_W-1:0];
        bft = '0;
        for (int i = 1; i <= BEAUFORT_MAX; i++)
        begin
            if (s4_avg_speed_reg >= bft_threshold(BFT_W'(i)))
                bft = BFT_W'(i);
        end
        gust_chg       = s4_tick_reg && (gust_sat != last_gust_reg);
        bft_chg        = s4_tick_reg && (bft != last_bft_reg);
        last_gust_next = s4_tick_reg ? gust_sat : last_gust_reg;
        last_bft_next  = s4_tick_reg ? bft : last_bft_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_gust_reg <= '0;
            last_bft_reg  <= '0;
        end
        else if (en_out && s4_valid_reg)
        begin
            last_gust_reg <= last_gust_next;
            last_bft_reg  <= last_bft_next;
        end
    end

    logic [OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk)
    begin
        if (en_out)
            out_data_reg <= {bft_chg, gust_chg, s4_tick_reg, last_bft_next,
                             last_gust_next, s4_gust_reg, s4_avg_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && s1_valid_reg && s2_valid_reg
         && s3_valid_reg && s4_valid_reg) |-> !s_tready)
        else $error("input taken while every stage is full and the output stalls");

    a_skip_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && skip_left_reg != '0) |=> skip_left_reg == $past(skip_left_reg) - 1'b1)
        else $error("report countdown did not step down by one");

    a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (en_out && s4_valid_reg && !s4_tick_reg) |=>
            ($stable(last_gust_reg) && $stable(last_bft_reg)))
        else $error("reported values changed on an interval without a report");

    a_flag_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg[54] || out_data_reg[55])) |-> out_data_reg[53])
        else $error("change flag raised on an interval without a report");

endmodule
